// ----- hw/rtl/nfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// nfsa_pkg
// Shared widths, codes, types and helpers for the next-fit slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package nfsa_pkg;

  // arena geometry
  localparam int MAX_SLOTS  = 2048;
  localparam int SEG_SHIFT  = 21;

  // field widths
  localparam int ADDR_W     = 48;
  localparam int SLOT_W     = 11;
  localparam int CNT_W      = 12;
  localparam int GEN_W      = 32;
  localparam int REQ_W      = 2;

  // used bitmap organization
  localparam int WORD_W     = 32;
  localparam int WORD_BIT_W = $clog2(WORD_W);
  localparam int NUM_WORDS  = MAX_SLOTS / WORD_W;
  localparam int WORD_AW    = $clog2(NUM_WORDS);

  // stream packing
  localparam int IN_FIELDS_W  = SLOT_W + ADDR_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + SLOT_W + ADDR_W + CNT_W + GEN_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CONTAINS = 2'd2;

  // configuration register indexes
  localparam logic CFG_ARENA_BASE = 1'b0;
  localparam logic CFG_SLOT_COUNT = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] arena_base;
    logic [CNT_W-1:0]  slot_count;
  } cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [SLOT_W-1:0] slot_index;
    logic [ADDR_W-1:0] query_address;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] result_slot;
    logic [ADDR_W-1:0] segment_address;
    logic [CNT_W-1:0]  slots_in_use;
    logic [GEN_W-1:0]  free_generation;
  } res_t;

  // bitmap port requests
  typedef struct packed {
    logic               rd_en;
    logic [WORD_AW-1:0] rd_addr;
    logic               wr_en;
    logic [WORD_AW-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
  } mem_req_t;

  typedef struct packed {
    logic                  found;
    logic [WORD_BIT_W-1:0] idx;
  } ffs_t;

  // lowest set bit of a bitmap word
  function automatic ffs_t find_first(input logic [WORD_W-1:0] v);
    ffs_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = WORD_BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/next_fit_segment_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// next_fit_segment_slot_allocator
// Next-fit allocator over an arena of equal segments with a used bitmap.
// ----------------------------------------------------------------------------
// sequence: free and contains pass through S_ADDR, S_RD, S_CHK, S_FIN and
//   S_OUT (S_CHK skipped for a slot out of range; only S_FIN and S_OUT when not
//   ready or unknown); alloc scans 32-slot bitmap words, at most 65 words, then
//   S_FIN and S_OUT (no scan with a zero slot count); one request at a time, set by
//   the single bitmap ram port and the word-per-cycle scan
// reset: synchronous; row valid bits mark all slots free at once, no clearing pass
`default_nettype none

module next_fit_segment_slot_allocator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic                                cfg_index,
  input  wire logic [nfsa_pkg::ADDR_W-1:0]         cfg_data,
  // request stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // slot_index, query_address, zero pad
  input  wire logic [nfsa_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type
  input  wire logic [nfsa_pkg::REQ_W-1:0]          s_axis_tuser,
  // result stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // ok, result_slot, segment_address, slots_in_use, free_generation
  output logic     [nfsa_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

  nfsa_pkg::cfg_t     cfg;
  nfsa_pkg::req_t     in_req;
  nfsa_pkg::res_t     res;
  nfsa_pkg::mem_req_t mem_req;
  logic [nfsa_pkg::WORD_W-1:0] rd_data;
  logic res_valid;
  logic res_take;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arena_base <= '0;
      cfg.slot_count <= nfsa_pkg::CNT_W'(nfsa_pkg::MAX_SLOTS);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nfsa_pkg::CFG_ARENA_BASE: cfg.arena_base <= cfg_data;
        nfsa_pkg::CFG_SLOT_COUNT: cfg.slot_count <= cfg_data[nfsa_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // unpack request beat
  always_comb begin
    in_req.req_type      = s_axis_tuser;
    in_req.slot_index    = s_axis_tdata[nfsa_pkg::SLOT_W-1:0];
    in_req.query_address = s_axis_tdata[nfsa_pkg::IN_FIELDS_W-1:nfsa_pkg::SLOT_W];
  end

  nfsa_bitmap u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  nfsa_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_req    (in_req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  // output register
  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_axis_tdata <= nfsa_pkg::OUT_DATA_W'({res.free_generation, res.slots_in_use,
                                             res.segment_address, res.result_slot,
                                             res.ok});
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nfsa_bitmap.sv -----
// ----------------------------------------------------------------------------
// nfsa_bitmap
// Used bitmap in a word-wide synchronous RAM with a registered read.
// A row valid bit per word makes never-written rows read as all free.
// ----------------------------------------------------------------------------
`default_nettype none

module nfsa_bitmap (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire nfsa_pkg::mem_req_t            req,
  output logic     [nfsa_pkg::WORD_W-1:0]    rd_data
);

  logic [nfsa_pkg::WORD_W-1:0]    mem [nfsa_pkg::NUM_WORDS];
  logic [nfsa_pkg::NUM_WORDS-1:0] row_valid;
  logic [nfsa_pkg::WORD_W-1:0]    rd_q;
  logic                           rd_row_ok;

  // ram array
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  // row valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_row_ok <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_row_ok <= row_valid[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_row_ok ? rd_q : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/nfsa_core.sv -----
// ----------------------------------------------------------------------------
// nfsa_core
// Request sequencer: next-fit word scan for alloc, read-modify-write for
// free, range check and bit test for contains, and the allocator counters.
// ----------------------------------------------------------------------------
`default_nettype none

module nfsa_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire nfsa_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire nfsa_pkg::req_t                in_req,
  output logic                               res_valid,
  input  wire logic                          res_take,
  output nfsa_pkg::res_t                     res,
  output nfsa_pkg::mem_req_t                 mem_req,
  input  wire logic [nfsa_pkg::WORD_W-1:0]   rd_data
);

  localparam int SLOT_W = nfsa_pkg::SLOT_W;
  localparam int CNT_W  = nfsa_pkg::CNT_W;
  localparam int WBW    = nfsa_pkg::WORD_BIT_W;
  localparam int WAW    = nfsa_pkg::WORD_AW;
  localparam int WW     = nfsa_pkg::WORD_W;
  localparam int ADDR_W = nfsa_pkg::ADDR_W;
  localparam int SHIFT  = nfsa_pkg::SEG_SHIFT;
  localparam int QS_W   = ADDR_W - SHIFT;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ADDR  = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_CHK   = 8'b0000_1000,
    S_SINIT = 8'b0001_0000,
    S_SCAN  = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;

  // request context
  logic [nfsa_pkg::REQ_W-1:0] req_type;
  logic [SLOT_W-1:0]          slot;
  logic [ADDR_W-1:0]          query;
  logic [CNT_W-1:0]           count;
  logic [SLOT_W-1:0]          start;
  logic                       in_range;
  logic                       ok_r;

  // scan issue and evaluate stages
  logic [WAW-1:0] iss_w;
  logic           iss_pass;
  logic           iss_act;
  logic [WAW-1:0] ev_w;
  logic           ev_pass;
  logic           ev_last;
  logic           ev_valid;

  // allocator state
  logic [SLOT_W-1:0]            cursor;
  logic [CNT_W-1:0]             used_total;
  logic [nfsa_pkg::GEN_W-1:0]   release_count;

  // effective slot count and search start at accept
  logic [CNT_W-1:0]  eff_count;
  logic [SLOT_W-1:0] start_next;
  logic              accept;

  always_comb begin
    eff_count  = (cfg.slot_count > CNT_W'(nfsa_pkg::MAX_SLOTS)) ?
                 CNT_W'(nfsa_pkg::MAX_SLOTS) : cfg.slot_count;
    start_next = ({1'b0, cursor} < eff_count) ? cursor : '0;
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // contains address to slot mapping
  logic [ADDR_W:0]  diff;
  logic [QS_W-1:0]  q_slot;
  logic             q_in_range;

  always_comb begin
    diff       = {1'b0, query} - {1'b0, cfg.arena_base};
    q_slot     = diff[ADDR_W-1:SHIFT];
    q_in_range = !diff[ADDR_W] && (q_slot[QS_W-1:CNT_W] == '0) &&
                 (q_slot[CNT_W-1:0] < count);
  end

  // issue side: last word of the current pass
  logic [CNT_W-1:0] iss_ub;
  logic [CNT_W-1:0] iss_ub_m1;
  logic             iss_at_end;
  logic             has_wrap;

  always_comb begin
    iss_ub     = iss_pass ? {1'b0, start} : count;
    iss_ub_m1  = iss_ub - CNT_W'(1);
    iss_at_end = (iss_w == iss_ub_m1[SLOT_W-1:WBW]);
    has_wrap   = (start != '0);
  end

  // evaluate side: mask the word to the pass window and find a free bit
  logic [CNT_W-1:0]  ev_lb;
  logic [CNT_W-1:0]  ev_ub;
  logic [WW-1:0]     mask_lo;
  logic [WW-1:0]     mask_hi;
  logic [WAW:0]      ev_w_ext;
  nfsa_pkg::ffs_t    ff;
  logic              found;
  logic [SLOT_W-1:0] found_slot;
  logic [CNT_W-1:0]  found_inc;

  always_comb begin
    ev_lb    = ev_pass ? '0 : {1'b0, start};
    ev_ub    = ev_pass ? {1'b0, start} : count;
    ev_w_ext = {1'b0, ev_w};
    mask_lo  = (ev_w > ev_lb[SLOT_W-1:WBW]) ? '1 : ('1 << ev_lb[WBW-1:0]);
    if (ev_w_ext < ev_ub[CNT_W-1:WBW]) begin
      mask_hi = '1;
    end else if (ev_w_ext == ev_ub[CNT_W-1:WBW]) begin
      mask_hi = ~('1 << ev_ub[WBW-1:0]);
    end else begin
      mask_hi = '0;
    end
    ff         = nfsa_pkg::find_first(mask_lo & mask_hi & ~rd_data);
    found      = ev_valid && ff.found;
    found_slot = {ev_w, ff.idx};
    found_inc  = {1'b0, found_slot} + CNT_W'(1);
  end

  // bitmap port control
  logic slot_bit;

  always_comb begin
    slot_bit        = rd_data[slot[WBW-1:0]];
    mem_req         = '0;
    mem_req.rd_addr = slot[SLOT_W-1:WBW];
    mem_req.wr_addr = slot[SLOT_W-1:WBW];
    mem_req.wr_data = rd_data;
    unique case (state)
      S_RD: begin
        mem_req.rd_en = in_range;
      end
      S_CHK: begin
        mem_req.wr_en   = (req_type == nfsa_pkg::REQ_FREE) && slot_bit;
        mem_req.wr_data = rd_data & ~(WW'(1) << slot[WBW-1:0]);
      end
      S_SCAN: begin
        mem_req.rd_en   = iss_act;
        mem_req.rd_addr = iss_w;
        mem_req.wr_en   = found;
        mem_req.wr_addr = ev_w;
        mem_req.wr_data = rd_data | (WW'(1) << ff.idx);
      end
      default: begin
      end
    endcase
  end

  // segment address of the current slot
  logic [ADDR_W-1:0] seg_addr;
  assign seg_addr = cfg.arena_base + (ADDR_W'(slot) << SHIFT);

  assign res_valid = (state == S_OUT);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      iss_act       <= 1'b0;
      ev_valid      <= 1'b0;
      cursor        <= '0;
      used_total    <= '0;
      release_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if ((cfg.arena_base == '0) ||
                ((in_req.req_type != nfsa_pkg::REQ_ALLOC) &&
                 (in_req.req_type != nfsa_pkg::REQ_FREE) &&
                 (in_req.req_type != nfsa_pkg::REQ_CONTAINS))) begin
              state <= S_FIN;
            end else if (in_req.req_type == nfsa_pkg::REQ_ALLOC) begin
              state <= S_SINIT;
            end else begin
              state <= S_ADDR;
            end
          end
        end
        S_ADDR: begin
          state <= S_RD;
        end
        S_RD: begin
          state <= in_range ? S_CHK : S_FIN;
        end
        S_CHK: begin
          if (slot_bit && (req_type == nfsa_pkg::REQ_FREE)) begin
            used_total    <= used_total - CNT_W'(1);
            cursor        <= slot;
            release_count <= release_count + nfsa_pkg::GEN_W'(1);
          end
          state <= S_FIN;
        end
        S_SINIT: begin
          if (count == '0) begin
            state <= S_FIN;
          end else begin
            iss_act  <= 1'b1;
            ev_valid <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (found) begin
            used_total <= used_total + CNT_W'(1);
            cursor     <= (found_inc < count) ? found_inc[SLOT_W-1:0] : '0;
            iss_act    <= 1'b0;
            ev_valid   <= 1'b0;
            state      <= S_FIN;
          end else if (ev_valid && ev_last) begin
            iss_act  <= 1'b0;
            ev_valid <= 1'b0;
            state    <= S_FIN;
          end else begin
            ev_valid <= iss_act;
            if (iss_act && iss_at_end && !(!iss_pass && has_wrap)) begin
              iss_act <= 1'b0;
            end
          end
        end
        S_FIN: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request payload and scan pointers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        req_type <= in_req.req_type;
        slot     <= in_req.slot_index;
        query    <= in_req.query_address;
        count    <= eff_count;
        start    <= start_next;
        ok_r     <= 1'b0;
      end
      S_ADDR: begin
        if (req_type == nfsa_pkg::REQ_CONTAINS) begin
          in_range <= q_in_range;
          slot     <= q_slot[SLOT_W-1:0];
        end else begin
          in_range <= ({1'b0, slot} < count);
        end
      end
      S_CHK: begin
        ok_r <= slot_bit;
      end
      S_SINIT: begin
        iss_w    <= start[SLOT_W-1:WBW];
        iss_pass <= 1'b0;
      end
      S_SCAN: begin
        if (iss_act) begin
          ev_w    <= iss_w;
          ev_pass <= iss_pass;
          ev_last <= iss_at_end && !(!iss_pass && has_wrap);
          if (iss_at_end) begin
            iss_pass <= 1'b1;
            iss_w    <= '0;
          end else begin
            iss_w <= iss_w + WAW'(1);
          end
        end
        if (found) begin
          slot <= found_slot;
          ok_r <= 1'b1;
        end
      end
      S_FIN: begin
        res.ok              <= ok_r;
        res.result_slot     <= ok_r ? slot : '0;
        res.segment_address <= ok_r ? seg_addr : '0;
        res.slots_in_use    <= used_total;
        res.free_generation <= release_count;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
